[rtl/psa_pkg.sv]
package psa_pkg;

    // Default fraction bits of the angle output
    localparam int unsigned ANGLE_FRAC_BITS_DEF = 7;

    // Iterations of the vectoring rotator, two per pipeline stage
    localparam int unsigned CORDIC_STEPS = 24;
    localparam int unsigned CORDIC_STAGES = CORDIC_STEPS / 2;

    // Configuration register indexes
    localparam logic [2:0] CFG_NORMAL_X = 3'd0;
    localparam logic [2:0] CFG_NORMAL_Y = 3'd1;
    localparam logic [2:0] CFG_NORMAL_Z = 3'd2;
    localparam logic [2:0] CFG_CENTER_X = 3'd3;
    localparam logic [2:0] CFG_CENTER_Y = 3'd4;
    localparam logic [2:0] CFG_CENTER_Z = 3'd5;

    // arctan(2^-i) in binary angle units, 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic [15:0] angle_deg;
        logic        degenerate;
    } t_out_item;

    // Configuration values and products derived from them
    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [31:0]        a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [30:0]        s;
        logic               axis_zero;
    } t_cfg_vals;

    // Rotator state plus flags carried to the output
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic               negx;
        logic               negy;
        logic               degen;
    } t_rot;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_LOAD,
        SQ_RUN
    } t_sq_state;

    // Position of the highest set bit plus one, zero for zero
    function automatic logic [6:0] bitlen64(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 7'(i + 1);
        end
        return n;
    endfunction

    // Arithmetic shift that truncates toward zero
    function automatic logic signed [33:0] shr_trunc(input logic signed [33:0] v,
                                                     input int unsigned sh);
        logic signed [33:0] m;
        m = -v;
        if (v < 0) return -(m >>> sh);
        return v >>> sh;
    endfunction

    // One vectoring iteration: drive y toward zero
    function automatic t_rot cordic_iter(input t_rot v, input int unsigned i);
        t_rot r;
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        r  = v;
        xs = shr_trunc(v.x, i);
        ys = shr_trunc(v.y, i);
        if (v.y > 0) begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + $signed({1'b0, ATAN_TURNS[i]});
        end else if (v.y < 0) begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - $signed({1'b0, ATAN_TURNS[i]});
        end
        return r;
    endfunction

endpackage

[rtl/psa_stream_if.sv]
interface psa_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/psa_cfg.sv]
module psa_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output psa_pkg::t_cfg_vals  o_cfg,
    output logic                o_busy
);

    logic signed [15:0] r_nx, r_ny, r_nz;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [31:0]        r_a;
    logic signed [31:0] r_b, r_c;
    logic signed [31:0] sq_x, sq_y, sq_z;
    logic [31:0]        nn;
    logic               norm_wr;

    psa_pkg::t_sq_state r_state, n_state;
    logic [63:0] r_rem, r_root;
    logic [4:0]  r_cnt;
    logic [63:0] bit_w, trial;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0;
            r_ny <= '0;
            r_nz <= 16'sd16384;
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psa_pkg::CFG_NORMAL_X: r_nx <= i_cfg_data[15:0];
                psa_pkg::CFG_NORMAL_Y: r_ny <= i_cfg_data[15:0];
                psa_pkg::CFG_NORMAL_Z: r_nz <= i_cfg_data[15:0];
                psa_pkg::CFG_CENTER_X: r_cx <= i_cfg_data;
                psa_pkg::CFG_CENTER_Y: r_cy <= i_cfg_data;
                psa_pkg::CFG_CENTER_Z: r_cz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign norm_wr = i_cfg_we && (i_cfg_idx == psa_pkg::CFG_NORMAL_X ||
                                  i_cfg_idx == psa_pkg::CFG_NORMAL_Y ||
                                  i_cfg_idx == psa_pkg::CFG_NORMAL_Z);

    // Squares and cross terms of the normal
    assign sq_x = r_nx * r_nx;
    assign sq_y = r_ny * r_ny;
    assign sq_z = r_nz * r_nz;
    assign nn   = sq_x + sq_y + sq_z;

    always_ff @(posedge i_clk) begin
        r_a <= sq_y + sq_z;
        r_b <= r_nx * r_ny;
        r_c <= r_nx * r_nz;
    end

    // Square root sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= psa_pkg::SQ_LOAD;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            psa_pkg::SQ_IDLE: if (norm_wr) n_state = psa_pkg::SQ_LOAD;
            psa_pkg::SQ_LOAD: n_state = psa_pkg::SQ_RUN;
            psa_pkg::SQ_RUN:  if (r_cnt == 5'd31) n_state = psa_pkg::SQ_IDLE;
            default:          n_state = psa_pkg::SQ_IDLE;
        endcase
        if (norm_wr) n_state = psa_pkg::SQ_LOAD;
    end

    // One result bit per cycle of floor(sqrt(nn * 2^30))
    assign bit_w = 64'd1 << (6'd62 - {r_cnt, 1'b0});
    assign trial = r_root + bit_w;

    always_ff @(posedge i_clk) begin
        if (r_state == psa_pkg::SQ_LOAD) begin
            r_rem  <= {nn, 30'd0} & 64'h3FFF_FFFF_FFFF_FFFF;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_state == psa_pkg::SQ_RUN) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + bit_w;
            end else begin
                r_root <= r_root >> 1;
            end
        end
    end

    always_comb begin
        o_cfg.nx        = r_nx;
        o_cfg.ny        = r_ny;
        o_cfg.nz        = r_nz;
        o_cfg.cx        = r_cx;
        o_cfg.cy        = r_cy;
        o_cfg.cz        = r_cz;
        o_cfg.a         = r_a;
        o_cfg.b         = r_b;
        o_cfg.c         = r_c;
        o_cfg.s         = r_root[30:0];
        o_cfg.axis_zero = (r_ny == 16'sd0) && (r_nz == 16'sd0);
    end

    assign o_busy = (r_state != psa_pkg::SQ_IDLE);

    a_norm_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_wr |=> r_state == psa_pkg::SQ_LOAD)
        else $error("normal write did not restart the root unit");

    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psa_pkg::SQ_RUN && r_cnt == 5'd31 && !norm_wr)
        |=> r_state == psa_pkg::SQ_IDLE)
        else $error("root unit ran past its last bit");

    a_load_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psa_pkg::SQ_LOAD && !norm_wr)
        |=> (r_state == psa_pkg::SQ_RUN && r_cnt == 5'd0))
        else $error("root unit did not start from its first bit");

endmodule

[rtl/psa_prep.sv]
module psa_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  psa_pkg::t_in_item  i_pt,
    input  psa_pkg::t_cfg_vals i_cfg,
    output logic               o_vld,
    output psa_pkg::t_rot      o_rot
);

    localparam logic signed [51:0] HI_LIM = 52'sd1 <<< 45;

    logic [10:1] r_vld;

    // stage 1: offset
    logic signed [32:0] r_d0, r_d1, r_d2;
    // stage 2: products
    logic signed [48:0] r_nyd2, r_nzd1, r_nzd0, r_nxd2, r_nxd1, r_nyd0;
    logic signed [49:0] r_ah0, r_bh1, r_ch2, r_al0, r_bl1, r_cl2;
    // stage 3: sums
    logic signed [51:0] r_hi, r_lo;
    logic signed [49:0] r_t;
    logic               r3_dg;
    // stage 4
    logic signed [63:0] r_dm;
    logic               r4_ex, r4_ny, r4_dg;
    logic [48:0]        r4_ym;
    // stage 5
    logic [62:0]        r5_xm;
    logic [48:0]        r5_ym;
    logic [4:0]         r5_k;
    logic               r5_ex, r5_nx, r5_ny, r5_dg;
    // stage 6
    logic [62:0]        r6_xm;
    logic [30:0]        r6_ys;
    logic [4:0]         r6_k;
    logic               r6_ex, r6_nx, r6_ny, r6_dg;
    // stage 7
    logic [62:0]        r7_xm;
    logic [61:0]        r7_pr;
    logic [4:0]         r7_k;
    logic               r7_ex, r7_nx, r7_ny, r7_dg;
    // stage 8
    logic [62:0]        r8_xa;
    logic [61:0]        r8_ya;
    logic               r8_nx, r8_ny, r8_dg;
    // stage 9
    logic [62:0]        r9_xa;
    logic [61:0]        r9_ya;
    logic [5:0]         r9_sh;
    logic               r9_nx, r9_ny, r9_dg;
    // stage 10
    logic [29:0]        r10_x, r10_y;
    logic               r10_nx, r10_ny, r10_dg;

    logic signed [16:0] dh0, dh1, dh2, dl0, dl1, dl2;
    logic signed [32:0] a_s;
    logic signed [49:0] cx, cy, cz;
    logic signed [51:0] lo_neg, lo_q;
    logic signed [49:0] t_neg;
    logic               hi_small;
    logic [6:0]         bl_y, bl_xy;

    assign dh0 = $signed(r_d0[32:16]);
    assign dh1 = $signed(r_d1[32:16]);
    assign dh2 = $signed(r_d2[32:16]);
    assign dl0 = $signed({1'b0, r_d0[15:0]});
    assign dl1 = $signed({1'b0, r_d1[15:0]});
    assign dl2 = $signed({1'b0, r_d2[15:0]});
    assign a_s = $signed({1'b0, i_cfg.a});

    assign cx = 50'(r_nyd2) - 50'(r_nzd1);
    assign cy = 50'(r_nzd0) - 50'(r_nxd2);
    assign cz = 50'(r_nxd1) - 50'(r_nyd0);

    assign hi_small = (r_hi < HI_LIM) && (r_hi > -HI_LIM);
    assign lo_neg   = -r_lo;
    assign lo_q     = r_lo[51] ? -(lo_neg >>> 16) : (r_lo >>> 16);
    assign t_neg    = -r_t;

    assign bl_y  = psa_pkg::bitlen64(64'(r4_ym));
    assign bl_xy = psa_pkg::bitlen64({1'b0, r8_xa} | {2'b0, r8_ya});

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (i_en) r_vld <= {r_vld[9:1], i_vld};
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // offset from the center
            r_d0 <= 33'(i_pt.point_x) - 33'(i_cfg.cx);
            r_d1 <= 33'(i_pt.point_y) - 33'(i_cfg.cy);
            r_d2 <= 33'(i_pt.point_z) - 33'(i_cfg.cz);

            // cross products and split cosine-term products
            r_nyd2 <= i_cfg.ny * r_d2;
            r_nzd1 <= i_cfg.nz * r_d1;
            r_nzd0 <= i_cfg.nz * r_d0;
            r_nxd2 <= i_cfg.nx * r_d2;
            r_nxd1 <= i_cfg.nx * r_d1;
            r_nyd0 <= i_cfg.ny * r_d0;
            r_ah0  <= a_s * dh0;
            r_bh1  <= i_cfg.b * dh1;
            r_ch2  <= i_cfg.c * dh2;
            r_al0  <= a_s * dl0;
            r_bl1  <= i_cfg.b * dl1;
            r_cl2  <= i_cfg.c * dl2;

            // combine; flag a vanishing projection
            r_hi  <= 52'(r_ah0) - 52'(r_bh1) - 52'(r_ch2);
            r_lo  <= 52'(r_al0) - 52'(r_bl1) - 52'(r_cl2);
            r_t   <= 50'(r_nzd1) - 50'(r_nyd2);
            r3_dg <= i_cfg.axis_zero || (cx == 50'sd0 && cy == 50'sd0 && cz == 50'sd0);

            // pick the cosine term exponent
            if (hi_small) r_dm <= (64'(r_hi) <<< 16) + 64'(r_lo);
            else          r_dm <= 64'(r_hi) + 64'(lo_q);
            r4_ex <= !hi_small;
            r4_ny <= r_t[49];
            r4_ym <= r_t[49] ? t_neg[48:0] : r_t[48:0];
            r4_dg <= r3_dg;

            // magnitudes and shift count of the sine term
            r5_xm <= r_dm[63] ? 63'(-r_dm) : r_dm[62:0];
            r5_nx <= r_dm[63];
            r5_ym <= r4_ym;
            r5_k  <= (bl_y > 7'd31) ? 5'(bl_y - 7'd31) : 5'd0;
            r5_ex <= r4_ex;
            r5_ny <= r4_ny;
            r5_dg <= r4_dg;

            r6_xm <= r5_xm;
            r6_ys <= 31'(r5_ym >> r5_k);
            r6_k  <= r5_k;
            r6_ex <= r5_ex;
            r6_nx <= r5_nx;
            r6_ny <= r5_ny;
            r6_dg <= r5_dg;

            // scale the sine term by the normal length
            r7_xm <= r6_xm;
            r7_pr <= r6_ys * i_cfg.s;
            r7_k  <= r6_k;
            r7_ex <= r6_ex;
            r7_nx <= r6_nx;
            r7_ny <= r6_ny;
            r7_dg <= r6_dg;

            // bring both terms to one exponent
            if (r7_ex) begin
                r8_xa <= r7_xm;
                r8_ya <= r7_pr >> (5'd31 - r7_k);
            end else if (r7_k > 5'd15) begin
                r8_xa <= r7_xm >> (r7_k - 5'd15);
                r8_ya <= r7_pr;
            end else begin
                r8_xa <= r7_xm;
                r8_ya <= r7_pr >> (5'd15 - r7_k);
            end
            r8_nx <= r7_nx;
            r8_ny <= r7_ny;
            r8_dg <= r7_dg;

            // find the common normalizing shift
            r9_xa <= r8_xa;
            r9_ya <= r8_ya;
            r9_sh <= (bl_xy > 7'd30) ? 6'(bl_xy - 7'd30) : 6'd0;
            r9_nx <= r8_nx;
            r9_ny <= r8_ny;
            r9_dg <= r8_dg;

            r10_x  <= 30'(r9_xa >> r9_sh);
            r10_y  <= 30'(r9_ya >> r9_sh);
            r10_nx <= r9_nx;
            r10_ny <= r9_ny;
            r10_dg <= r9_dg;
        end
    end

    assign o_vld       = r_vld[10];
    assign o_rot.x     = $signed({4'b0, r10_x});
    assign o_rot.y     = $signed({4'b0, r10_y});
    assign o_rot.z     = '0;
    assign o_rot.negx  = r10_nx;
    assign o_rot.negy  = r10_ny;
    assign o_rot.degen = r10_dg;

endmodule

[rtl/psa_cordic_stage.sv]
module psa_cordic_stage #(
    parameter int unsigned STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  psa_pkg::t_rot i_rot,
    output logic          o_vld,
    output psa_pkg::t_rot o_rot
);

    logic          r_vld;
    psa_pkg::t_rot r_rot;
    psa_pkg::t_rot mid;

    // Two iterations of the rotator
    assign mid = psa_pkg::cordic_iter(i_rot, STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else if (i_en) r_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_rot <= psa_pkg::cordic_iter(mid, STEP + 1);
    end

    assign o_vld = r_vld;
    assign o_rot = r_rot;

endmodule

[rtl/psa_post.sv]
module psa_post #(
    parameter int unsigned ANGLE_FRAC_BITS = psa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  psa_pkg::t_rot       i_rot,
    output logic                o_vld,
    output psa_pkg::t_out_item  o_item
);

    localparam int unsigned FW = 9 + ANGLE_FRAC_BITS;
    localparam int unsigned PW = 32 + FW;
    localparam logic [FW-1:0] FULL = FW'(360 << ANGLE_FRAC_BITS);

    logic [3:1]    r_vld;
    logic [31:0]   r_theta;
    logic [PW-1:0] r_prod;
    logic [2:1]    r_dg;
    logic [15:0]   r_angle;
    logic          r_degen;

    logic [30:0]   zc;
    logic [31:0]   theta;
    logic [PW:0]   rnd;
    logic [FW-1:0] deg;

    // Clamp the rotator angle to a quarter turn and place it in its quadrant
    always_comb begin
        if (i_rot.z < 0)                     zc = '0;
        else if (i_rot.z > 33'sd1073741824)  zc = 31'd1073741824;
        else                                 zc = i_rot.z[30:0];
        case ({i_rot.negx, i_rot.negy})
            2'b00:   theta = 32'(zc);
            2'b10:   theta = 32'h8000_0000 - 32'(zc);
            2'b11:   theta = 32'h8000_0000 + 32'(zc);
            default: theta = 32'd0 - 32'(zc);
        endcase
    end

    // Round the turn fraction to degrees and wrap a full turn
    assign rnd = (PW + 1)'(r_prod) + ((PW + 1)'(1) << 31);
    always_comb begin
        deg = FW'(rnd >> 32);
        if (deg >= FULL) deg = deg - FULL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (i_en) r_vld <= {r_vld[2:1], i_vld};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_theta <= theta;
            r_dg[1] <= i_rot.degen;
            r_prod  <= PW'(r_theta) * PW'(FULL);
            r_dg[2] <= r_dg[1];
            r_angle <= r_dg[2] ? 16'd0 : 16'(deg);
            r_degen <= r_dg[2];
        end
    end

    assign o_vld             = r_vld[3];
    assign o_item.angle_deg  = r_angle;
    assign o_item.degenerate = r_degen;

endmodule

[rtl/plane_projected_signed_angle_unit.sv]
// Channel  Dir  Payload                          Handshake
// i_pt     in   point_x, point_y, point_z        valid / ready
// o_res    out  angle_deg, degenerate            valid / ready
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data  write on i_cfg_we, no wait
//
// One item enters per cycle unless o_res stalls or the square root runs; each result
// passes 10 preparation stages, 12 rotator stages of two iterations and 3 output stages.
// After reset and after each normal write, a bit-serial square root of |n|^2
// runs and holds i_pt.ready low; center writes take effect at once.
// Reset is synchronous, active low; it clears the valid bits, loads the register
// defaults and restarts the root unit.
// A stall at o_res freezes every stage together, so nothing is lost or repeated.
module plane_projected_signed_angle_unit #(
    parameter int unsigned ANGLE_FRAC_BITS = psa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psa_stream_if.sink   i_pt,
    psa_stream_if.source o_res,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    psa_pkg::t_cfg_vals w_cfg;
    logic               w_busy;
    logic               w_en;
    logic               w_prep_vld;
    psa_pkg::t_rot      w_prep_rot;
    logic               w_vld [psa_pkg::CORDIC_STAGES + 1];
    psa_pkg::t_rot      w_rot [psa_pkg::CORDIC_STAGES + 1];
    logic               w_out_vld;
    psa_pkg::t_out_item w_out_item;

    // Advance the whole pipeline unless the output item is held
    assign w_en       = !w_out_vld || o_res.ready;
    assign i_pt.ready = w_en && !w_busy;

    psa_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_busy     (w_busy)
    );

    psa_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pt.valid && !w_busy),
        .i_pt    (i_pt.data),
        .i_cfg   (w_cfg),
        .o_vld   (w_prep_vld),
        .o_rot   (w_prep_rot)
    );

    assign w_vld[0] = w_prep_vld;
    assign w_rot[0] = w_prep_rot;

    for (genvar g = 0; g < psa_pkg::CORDIC_STAGES; g++) begin : g_cordic
        psa_cordic_stage #(
            .STEP (2 * g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_rot   (w_rot[g]),
            .o_vld   (w_vld[g + 1]),
            .o_rot   (w_rot[g + 1])
        );
    end

    psa_post #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[psa_pkg::CORDIC_STAGES]),
        .i_rot   (w_rot[psa_pkg::CORDIC_STAGES]),
        .o_vld   (w_out_vld),
        .o_item  (w_out_item)
    );

    assign o_res.valid = w_out_vld;
    assign o_res.data  = w_out_item;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |-> !w_busy)
        else $error("item accepted while the root unit runs");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.degenerate) |-> o_res.data.angle_deg == 16'd0)
        else $error("degenerate item carries a nonzero angle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.data)))
        else $error("held output item changed");

endmodule
